[rtl/jtdtm_pkg.sv]
// Shared types, codes and the TAP transition function of the JTAG debug transport.
`timescale 1ns / 1ps
`default_nettype none

package jtdtm_pkg;

    localparam int ADDR_BITS_DEF = 6;
    localparam int IR_W          = 5;
    localparam int REQ_ADDR_W    = 6;
    localparam int DATA_W        = 32;
    localparam int ID_LEN        = 32;
    localparam int IDLE_W        = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 48;

    localparam logic [IR_W-1:0] IR_IDCODE = 5'h01;
    localparam logic [IR_W-1:0] IR_DTMCS  = 5'h10;
    localparam logic [IR_W-1:0] IR_DMI    = 5'h11;
    localparam logic [IR_W-1:0] IR_BYPASS = 5'h1f;

    localparam logic [CFG_IDX_W-1:0] CFG_ID_CODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_NEED = 1'b1;

    localparam int DTMCS_DMIRESET_BIT  = 16;
    localparam int DTMCS_HARDRESET_BIT = 17;

    typedef enum logic [3:0] {
        TAP_TLR, TAP_RTI, TAP_SEL_DR, TAP_CAP_DR, TAP_SH_DR, TAP_EX1_DR, TAP_PA_DR,
        TAP_EX2_DR, TAP_UPD_DR, TAP_SEL_IR, TAP_CAP_IR, TAP_SH_IR, TAP_EX1_IR,
        TAP_PA_IR, TAP_EX2_IR, TAP_UPD_IR
    } tap_state_t;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_READ  = 2'd1,
        PEND_WRITE = 2'd2
    } pend_t;

    // What the current word does to the TAP.
    typedef struct packed {
        logic rise;   // TCK rising: shift and transition
        logic fall;   // any other pin sample: falling-edge actions
        logic resp;   // debug module response word
    } step_t;

    typedef struct packed {
        logic [DATA_W-1:0]     req_wdata;
        logic [REQ_ADDR_W-1:0] req_address;
        logic                  req_write;
        logic                  req_valid;
        logic                  idle_tick;
        logic                  tdo;
    } res_t;

    function automatic tap_state_t tap_next(input tap_state_t st, input logic tms);
        tap_state_t nx;
        nx = TAP_TLR;
        unique case (st)
            TAP_TLR:    nx = tms ? TAP_TLR    : TAP_RTI;
            TAP_RTI:    nx = tms ? TAP_SEL_DR : TAP_RTI;
            TAP_SEL_DR: nx = tms ? TAP_SEL_IR : TAP_CAP_DR;
            TAP_CAP_DR: nx = tms ? TAP_EX1_DR : TAP_SH_DR;
            TAP_SH_DR:  nx = tms ? TAP_EX1_DR : TAP_SH_DR;
            TAP_EX1_DR: nx = tms ? TAP_UPD_DR : TAP_PA_DR;
            TAP_PA_DR:  nx = tms ? TAP_EX2_DR : TAP_PA_DR;
            TAP_EX2_DR: nx = tms ? TAP_UPD_DR : TAP_SH_DR;
            TAP_UPD_DR: nx = tms ? TAP_SEL_DR : TAP_RTI;
            TAP_SEL_IR: nx = tms ? TAP_TLR    : TAP_CAP_IR;
            TAP_CAP_IR: nx = tms ? TAP_EX1_IR : TAP_SH_IR;
            TAP_SH_IR:  nx = tms ? TAP_EX1_IR : TAP_SH_IR;
            TAP_EX1_IR: nx = tms ? TAP_UPD_IR : TAP_PA_IR;
            TAP_PA_IR:  nx = tms ? TAP_EX2_IR : TAP_PA_IR;
            TAP_EX2_IR: nx = tms ? TAP_UPD_IR : TAP_SH_IR;
            TAP_UPD_IR: nx = tms ? TAP_SEL_DR : TAP_RTI;
            default:    nx = TAP_TLR;
        endcase
        return nx;
    endfunction

endpackage

`default_nettype wire

[rtl/jtdtm_tap.sv]
// TAP controller state register, held pin levels and edge decode.
`timescale 1ns / 1ps
`default_nettype none

module jtdtm_tap (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     advance,
    input  wire                     op,
    input  wire                     tck,
    input  wire                     tms,
    input  wire                     tdi,
    input  wire                     hard_rst,
    output jtdtm_pkg::tap_state_t   tap_state,
    output jtdtm_pkg::step_t        step,
    output logic                    last_tdi
);
    import jtdtm_pkg::*;

    tap_state_t state_reg, state_next;
    logic       last_tck_reg, last_tms_reg, last_tdi_reg;
    logic       pin;

    // Next state: rising TCK steps on the last TMS; a hard reset gives TLR.
    always_comb begin
        state_next = state_reg;
        if (step.rise) begin
            state_next = tap_next(state_reg, last_tms_reg);
        end else if (hard_rst) begin
            state_next = TAP_TLR;
        end
    end

    // Outputs: classify the word being processed.
    always_comb begin
        pin       = advance && !op;
        step.rise = pin && !last_tck_reg && tck;
        step.fall = pin && !(!last_tck_reg && tck);
        step.resp = advance && op;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= TAP_TLR;
            last_tck_reg <= 1'b0;
            last_tms_reg <= 1'b0;
            last_tdi_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pin) begin
                last_tck_reg <= tck;
                last_tms_reg <= tms;
                last_tdi_reg <= tdi;
            end
        end
    end

    assign tap_state = state_reg;
    assign last_tdi  = last_tdi_reg;

endmodule

`default_nettype wire

[rtl/jtdtm_core.sv]
// Instruction, shift, DMI and status registers with capture, shift and update.
`timescale 1ns / 1ps
`default_nettype none

module jtdtm_core #(
    parameter int ADDR_BITS = jtdtm_pkg::ADDR_BITS_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  jtdtm_pkg::step_t                     step,
    input  jtdtm_pkg::tap_state_t                tap_state,
    input  wire                                  last_tdi,
    input  wire  [jtdtm_pkg::DATA_W-1:0]         resp_data,
    input  wire                                  resp_ok,
    input  wire  [jtdtm_pkg::DATA_W-1:0]         id_code,
    input  wire  [jtdtm_pkg::IDLE_W-1:0]         idle_need,
    output logic                                 hard_rst,
    output jtdtm_pkg::res_t                      res
);
    import jtdtm_pkg::*;

    localparam int DMI_LEN = ADDR_BITS + 34;
    localparam int LEN_W   = $clog2(DMI_LEN + 1);
    localparam logic [DMI_LEN-1:0] DTMCS_VAL = DMI_LEN'((ADDR_BITS % 64) * 16 + 1);
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd2;
    localparam logic [1:0] ST_BUSY = 2'd3;

    logic [IR_W-1:0]    instr_reg, instr_next;
    logic [DMI_LEN-1:0] shift_reg, shift_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [DMI_LEN-1:0] dmi_reg, dmi_next;
    logic               bypass_reg, bypass_next;
    logic               stuck_reg, stuck_next;
    logic [IDLE_W-1:0]  idle_reg, idle_next;
    logic               tdo_reg, tdo_next;
    pend_t              pend_reg, pend_next;

    logic [DMI_LEN-1:0]            shifted;
    logic [DMI_LEN+REQ_ADDR_W-1:0] shift_ext;
    logic                          dmi_busy;

    assign shift_ext = {{REQ_ADDR_W{1'b0}}, shift_reg};
    assign dmi_busy  = (idle_reg != '0) || stuck_reg || (pend_reg != PEND_NONE);

    // Shift right and drop the held TDI into the top bit of the selected length.
    always_comb begin
        shifted = shift_reg >> 1;
        for (int i = 0; i < DMI_LEN; i++) begin
            if (len_reg == LEN_W'(i + 1)) begin
                shifted[i] = last_tdi;
            end
        end
    end

    always_comb begin
        instr_next  = instr_reg;
        shift_next  = shift_reg;
        len_next    = len_reg;
        dmi_next    = dmi_reg;
        bypass_next = bypass_reg;
        stuck_next  = stuck_reg;
        idle_next   = idle_reg;
        tdo_next    = tdo_reg;
        pend_next   = pend_reg;
        hard_rst    = 1'b0;
        res         = '0;

        if (step.rise) begin
            if (tap_state == TAP_SH_DR) begin
                shift_next = shifted;
            end else if (tap_state == TAP_SH_IR) begin
                instr_next = {last_tdi, instr_reg[IR_W-1:1]};
            end
        end else if (step.fall) begin
            unique case (tap_state)
                TAP_RTI: begin
                    if (idle_reg != '0) begin
                        idle_next = idle_reg - 1'b1;
                    end
                    res.idle_tick = 1'b1;
                end
                TAP_TLR: begin
                    instr_next = IR_IDCODE;
                end
                TAP_CAP_DR: begin
                    unique case (instr_reg)
                        IR_IDCODE: begin
                            shift_next = DMI_LEN'(id_code);
                            len_next   = LEN_W'(ID_LEN);
                        end
                        IR_DTMCS: begin
                            shift_next = DTMCS_VAL;
                            len_next   = LEN_W'(ID_LEN);
                        end
                        IR_DMI: begin
                            if (dmi_busy) begin
                                shift_next = DMI_LEN'(ST_BUSY);
                                stuck_next = 1'b1;
                            end else begin
                                shift_next = dmi_reg;
                            end
                            len_next = LEN_W'(DMI_LEN);
                        end
                        IR_BYPASS: begin
                            shift_next = DMI_LEN'(bypass_reg);
                            len_next   = LEN_W'(1);
                        end
                        default: ;
                    endcase
                end
                TAP_SH_DR: begin
                    tdo_next = shift_reg[0];
                end
                TAP_UPD_DR: begin
                    if (instr_reg == IR_DTMCS) begin
                        if (shift_reg[DTMCS_DMIRESET_BIT]) begin
                            stuck_next = 1'b0;
                        end
                        if (shift_reg[DTMCS_HARDRESET_BIT]) begin
                            hard_rst   = 1'b1;
                            stuck_next = 1'b0;
                            idle_next  = '0;
                            dmi_next   = '0;
                            pend_next  = PEND_NONE;
                        end
                    end else if (instr_reg == IR_BYPASS) begin
                        bypass_next = shift_reg[0];
                    end else if (instr_reg == IR_DMI && !stuck_reg &&
                                 pend_reg == PEND_NONE) begin
                        dmi_next = shift_reg;
                        if (shift_reg[1:0] == PEND_READ || shift_reg[1:0] == PEND_WRITE) begin
                            pend_next       = pend_t'(shift_reg[1:0]);
                            res.req_valid   = 1'b1;
                            res.req_write   = (shift_reg[1:0] == PEND_WRITE);
                            res.req_address = shift_ext[34 +: REQ_ADDR_W];
                            if (shift_reg[1:0] == PEND_WRITE) begin
                                res.req_wdata = shift_reg[2 +: DATA_W];
                            end
                        end else begin
                            dmi_next[1:0] = ST_OK;
                        end
                        idle_next = idle_need;
                    end
                end
                TAP_SH_IR: begin
                    tdo_next = instr_reg[0];
                end
                default: ;
            endcase
        end else if (step.resp) begin
            if (pend_reg != PEND_NONE) begin
                if (!resp_ok) begin
                    dmi_next[1:0] = ST_FAIL;
                end else begin
                    if (pend_reg == PEND_READ) begin
                        dmi_next[2 +: DATA_W] = resp_data;
                    end
                    dmi_next[1:0] = ST_OK;
                end
                pend_next = PEND_NONE;
            end
        end

        res.tdo = tdo_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            instr_reg  <= IR_IDCODE;
            shift_reg  <= '0;
            len_reg    <= '0;
            dmi_reg    <= '0;
            bypass_reg <= 1'b0;
            stuck_reg  <= 1'b0;
            idle_reg   <= '0;
            tdo_reg    <= 1'b0;
            pend_reg   <= PEND_NONE;
        end else begin
            instr_reg  <= instr_next;
            shift_reg  <= shift_next;
            len_reg    <= len_next;
            dmi_reg    <= dmi_next;
            bypass_reg <= bypass_next;
            stuck_reg  <= stuck_next;
            idle_reg   <= idle_next;
            tdo_reg    <= tdo_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

`default_nettype wire

[rtl/jtag_debug_transport_module_unit.sv]
// Top level of the JTAG debug transport: stream channels, configuration and staging registers.
`timescale 1ns / 1ps
`default_nettype none

// The block models a JTAG TAP carrying a debug transport module. Each input
// word is either a pin sample (s_tuser = 0: TCK, TMS, TDI levels) or a
// debug module response to the request last issued (s_tuser = 1). A rising
// TCK shifts the selected register and steps the TAP on the TMS and TDI held
// from the previous sample; any other sample runs the falling-edge actions.
// Every input word produces exactly one result word carrying TDO, an idle
// tick and, on a DMI update, a read or write request to the debug module.
//
// Input words land in an input register; the TAP and register update runs
// combinationally from there into the result register, so each word passes
// the input register and then the result register. One word per cycle is
// sustained while the receiver takes results. When the receiver stalls, the
// result holds and s_tready falls once the input register holds a word.
// The cfg channel is always ready and writes id_code (index 0) or
// idle_cycles_needed (index 1); write it only while the block is idle.
// The synchronous reset puts the TAP in Test-Logic-Reset with IDCODE
// selected, clears all DTM state and restores the register defaults.
module jtag_debug_transport_module_unit #(
    parameter int ADDR_BITS = jtdtm_pkg::ADDR_BITS_DEF
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // Input channel.
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // tdata from bit 0: tck, tms, tdi, resp_data[31:0], resp_ok, zero fill.
    input  wire  [jtdtm_pkg::IN_TDATA_W-1:0]      s_tdata,
    // tuser: op (0 pin sample, 1 debug module response).
    input  wire                                   s_tuser,
    // Result channel.
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // tdata from bit 0: tdo, idle_tick, req_valid, req_write,
    // req_address[5:0], req_wdata[31:0], zero fill.
    output logic [jtdtm_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // Configuration write channel.
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [jtdtm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [jtdtm_pkg::DATA_W-1:0]          cfg_data
);
    import jtdtm_pkg::*;

    localparam int RES_W = $bits(res_t);

    logic                  in_vld_reg;
    logic                  in_op_reg;
    logic [35:0]           in_data_reg;
    logic                  out_vld_reg;
    res_t                  out_res_reg;
    logic [DATA_W-1:0]     id_code_reg;
    logic [IDLE_W-1:0]     idle_need_reg;

    logic                  advance;
    logic                  hard_rst;
    tap_state_t            tap_state;
    step_t                 step;
    logic                  last_tdi;
    res_t                  res;

    // The held word is processed whenever the result register can take it.
    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {{(OUT_TDATA_W - RES_W){1'b0}}, out_res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            id_code_reg   <= DATA_W'(1);
            idle_need_reg <= '0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_ID_CODE:   id_code_reg   <= cfg_data;
                    CFG_IDLE_NEED: idle_need_reg <= cfg_data[IDLE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata[35:0];
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    jtdtm_tap u_tap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .op        (in_op_reg),
        .tck       (in_data_reg[0]),
        .tms       (in_data_reg[1]),
        .tdi       (in_data_reg[2]),
        .hard_rst  (hard_rst),
        .tap_state (tap_state),
        .step      (step),
        .last_tdi  (last_tdi)
    );

    jtdtm_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .tap_state (tap_state),
        .last_tdi  (last_tdi),
        .resp_data (in_data_reg[34:3]),
        .resp_ok   (in_data_reg[35]),
        .id_code   (id_code_reg),
        .idle_need (idle_need_reg),
        .hard_rst  (hard_rst),
        .res       (res)
    );

endmodule

`default_nettype wire
